FILE: rtl/core/hhlp_pkg.sv
// shared types and defaults for the http header length parser
package hhlp_pkg;

  localparam int OffsetBitsDef = 16;
  localparam int LengthBitsDef = 32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_first;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic valid;
    logic header_found;
    logic length_found;
  } res_flags_t;

endpackage

FILE: rtl/core/hhlp_if.sv
// item channel interfaces for the http header length parser
interface hhlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_first;
  logic       is_last;

  modport source (output valid, output data_byte, output is_first, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_first, input is_last, output ready);
endinterface

interface hhlp_out_if #(
  parameter int OFFSET_BITS = hhlp_pkg::OffsetBitsDef,
  parameter int LENGTH_BITS = hhlp_pkg::LengthBitsDef
);
  logic                   valid;
  logic                   ready;
  logic                   header_found;
  logic [OFFSET_BITS-1:0] header_end;
  logic                   length_found;
  logic [LENGTH_BITS-1:0] content_length;

  modport source (output valid, output header_found, output header_end,
                  output length_found, output content_length, input ready);
  modport sink (input valid, input header_found, input header_end,
                input length_found, input content_length, output ready);
endinterface

FILE: rtl/core/hhlp_core.sv
// per-byte parser state and next-state logic
module hhlp_core #(
  parameter int OFFSET_BITS = hhlp_pkg::OffsetBitsDef,
  parameter int LENGTH_BITS = hhlp_pkg::LengthBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  hhlp_pkg::item_t        item_i,
  output hhlp_pkg::res_flags_t   flags_o,
  output logic [OFFSET_BITS-1:0] header_end_o,
  output logic [LENGTH_BITS-1:0] content_length_o
);

  localparam logic [2:0] PhNameUp   = 3'd0;
  localparam logic [2:0] PhNameLo   = 3'd1;
  localparam logic [2:0] PhColon    = 3'd2;
  localparam logic [2:0] PhSkip     = 3'd3;
  localparam logic [2:0] PhDigits   = 3'd4;
  localparam logic [2:0] PhTailWait = 3'd5;
  localparam logic [2:0] PhTailOk   = 3'd6;
  localparam logic [2:0] PhIgnore   = 3'd7;

  localparam logic [3:0] NameLast = 4'd14;

  localparam logic [7:0] ChCr  = 8'h0d;
  localparam logic [7:0] ChLf  = 8'h0a;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;

  localparam int WideBits = LENGTH_BITS + 4;

  function automatic logic [7:0] name_char(input logic upper, input logic [3:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      4'd0:    c = upper ? "C" : "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = upper ? "L" : "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  logic [OFFSET_BITS-1:0] off_q, off_d, cur_off;
  logic [1:0]             mark_q, mark_d, cur_mark;
  logic [2:0]             phase_q, phase_d, cur_phase;
  logic [3:0]             idx_q, idx_d, cur_idx;
  logic [LENGTH_BITS-1:0] acc_q, acc_d, cur_acc;
  logic [LENGTH_BITS-1:0] commit_q, commit_d, cur_commit;
  logic                   seen_q, seen_d, cur_seen;
  logic                   done_q, done_d, cur_done;

  logic [7:0]             b;
  logic                   is_ws, is_dig, found;
  logic [WideBits-1:0]    wide;
  logic [LENGTH_BITS-1:0] acc_dig;

  assign b      = item_i.data_byte;
  assign is_ws  = (b == ChSp) || (b == ChTab);
  assign is_dig = (b >= "0") && (b <= "9");

  // current state, cleared when a new message starts
  always_comb begin
    cur_off    = item_i.is_first ? '0 : off_q;
    cur_mark   = item_i.is_first ? '0 : mark_q;
    cur_phase  = item_i.is_first ? PhNameUp : phase_q;
    cur_idx    = item_i.is_first ? '0 : idx_q;
    cur_acc    = item_i.is_first ? '0 : acc_q;
    cur_commit = item_i.is_first ? '0 : commit_q;
    cur_seen   = item_i.is_first ? 1'b0 : seen_q;
    cur_done   = item_i.is_first ? 1'b0 : done_q;
  end

  // acc * 10 + digit, saturating
  always_comb begin
    wide = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0}
         + {{LENGTH_BITS{1'b0}}, b[3:0]};
    acc_dig = (wide[WideBits-1:LENGTH_BITS] != '0) ? '1 : wide[LENGTH_BITS-1:0];
  end

  always_comb begin
    off_d    = cur_off;
    mark_d   = cur_mark;
    phase_d  = cur_phase;
    idx_d    = cur_idx;
    acc_d    = cur_acc;
    commit_d = cur_commit;
    seen_d   = cur_seen;
    done_d   = cur_done;
    found    = 1'b0;
    flags_o  = '0;
    header_end_o     = '0;
    content_length_o = '0;

    if (!cur_done) begin
      if (cur_off != '1) begin
        off_d = cur_off + 1'b1;
      end

      if (b == ChLf) begin
        if (!cur_seen && ((cur_phase == PhSkip) || (cur_phase == PhDigits) ||
                          (cur_phase == PhTailOk))) begin
          seen_d   = 1'b1;
          commit_d = cur_acc;
        end
        phase_d = PhNameUp;
        idx_d   = '0;
        acc_d   = '0;
      end else begin
        unique case (cur_phase)
          PhNameUp, PhNameLo: begin
            if (cur_idx == '0) begin
              if (b == "C") begin
                phase_d = PhNameUp;
                idx_d   = 4'd1;
              end else if (b == "c") begin
                phase_d = PhNameLo;
                idx_d   = 4'd1;
              end else begin
                phase_d = PhIgnore;
              end
            end else if ((cur_idx <= NameLast) &&
                         (b == name_char(cur_phase == PhNameUp, cur_idx))) begin
              idx_d = cur_idx + 4'd1;
              if (cur_idx == NameLast) begin
                phase_d = PhColon;
              end
            end else begin
              phase_d = PhIgnore;
            end
          end
          PhColon: begin
            if (b == ChCr) begin
              phase_d = PhTailWait;
            end else if (is_ws) begin
              phase_d = PhSkip;
            end else if (is_dig) begin
              acc_d   = acc_dig;
              phase_d = PhDigits;
            end else begin
              phase_d = PhTailOk;
            end
          end
          PhSkip: begin
            if (is_dig) begin
              acc_d   = acc_dig;
              phase_d = PhDigits;
            end else if (!is_ws) begin
              phase_d = PhTailOk;
            end
          end
          PhDigits: begin
            if (is_dig) begin
              acc_d = acc_dig;
            end else begin
              phase_d = PhTailOk;
            end
          end
          PhTailWait: begin
            if (b != ChCr) begin
              phase_d = PhTailOk;
            end
          end
          default: begin
          end
        endcase
      end

      // cr lf cr lf tracking
      if (b == ChCr) begin
        mark_d = (cur_mark == 2'd2) ? 2'd3 : 2'd1;
      end else if (b == ChLf) begin
        if (cur_mark == 2'd1) begin
          mark_d = 2'd2;
        end else if (cur_mark == 2'd3) begin
          found = 1'b1;
        end else begin
          mark_d = 2'd0;
        end
      end else begin
        mark_d = 2'd0;
      end

      if (found) begin
        done_d = 1'b1;
        mark_d = 2'd0;
        flags_o.valid        = 1'b1;
        flags_o.header_found = 1'b1;
        flags_o.length_found = seen_d;
        header_end_o         = off_d;
        content_length_o     = seen_d ? commit_d : '0;
      end else if (item_i.is_last) begin
        done_d        = 1'b1;
        flags_o.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      mark_q   <= '0;
      phase_q  <= PhNameUp;
      idx_q    <= '0;
      acc_q    <= '0;
      commit_q <= '0;
      seen_q   <= 1'b0;
      done_q   <= 1'b0;
    end else if (step_i) begin
      off_q    <= off_d;
      mark_q   <= mark_d;
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      acc_q    <= acc_d;
      commit_q <= commit_d;
      seen_q   <= seen_d;
      done_q   <= done_d;
    end
  end

endmodule

FILE: rtl/core/http_header_length_parser_top.sv
// top level: input register, parser step, result register
//
// channel  dir  handshake     payload
// in_i     in   valid/ready   data_byte, is_first, is_last
// out_o    out  valid/ready   header_found, header_end, length_found, content_length
//
// one byte per cycle while out_o is not stalled; a byte is parsed while it sits
// in the input register and its result, if any, shows on out_o in the next cycle
// the input register frees itself when the result register is empty or drained,
// so a stalled out_o holds one result and one byte before in_i.ready drops
// reset clears parser state and both valid flags
module http_header_length_parser_top #(
  parameter int OFFSET_BITS = hhlp_pkg::OffsetBitsDef,
  parameter int LENGTH_BITS = hhlp_pkg::LengthBitsDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  hhlp_in_if.sink  in_i,
  hhlp_out_if.source out_o
);

  hhlp_pkg::item_t      item_q;
  logic                 in_valid_q;
  hhlp_pkg::res_flags_t flags;
  logic [OFFSET_BITS-1:0] hend;
  logic [LENGTH_BITS-1:0] clen;

  logic                   out_valid_q;
  logic                   hfound_q, lfound_q;
  logic [OFFSET_BITS-1:0] hend_q;
  logic [LENGTH_BITS-1:0] clen_q;

  logic step, accept;

  assign step   = in_valid_q && (!out_valid_q || out_o.ready);
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_byte <= in_i.data_byte;
      item_q.is_first  <= in_i.is_first;
      item_q.is_last   <= in_i.is_last;
    end
  end

  hhlp_core #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .item_i           (item_q),
    .flags_o          (flags),
    .header_end_o     (hend),
    .content_length_o (clen)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= flags.valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && flags.valid) begin
      hfound_q <= flags.header_found;
      lfound_q <= flags.length_found;
      hend_q   <= hend;
      clen_q   <= clen;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.header_found   = hfound_q;
  assign out_o.header_end     = hend_q;
  assign out_o.length_found   = lfound_q;
  assign out_o.content_length = clen_q;

endmodule

FILE: rtl/core/hhlp_checker.sv
// port-level checks for the http header length parser
module hhlp_checker #(
  parameter int OFFSET_BITS = hhlp_pkg::OffsetBitsDef,
  parameter int LENGTH_BITS = hhlp_pkg::LengthBitsDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic                   header_found_i,
  input logic [OFFSET_BITS-1:0] header_end_i,
  input logic                   length_found_i,
  input logic [LENGTH_BITS-1:0] content_length_i
);

  logic out_take;
  assign out_take = out_valid_i && out_ready_i;

  // stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(header_found_i) &&
      $stable(header_end_i) && $stable(length_found_i) && $stable(content_length_i))
    else $error("stalled result changed");

  // not-found result carries no offset and no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !header_found_i |->
      (header_end_i == '0) && !length_found_i && (content_length_i == '0))
    else $error("not-found result has payload");

  // no length line means zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !length_found_i |-> content_length_i == '0)
    else $error("length without a length line");

  // a found marker takes at least four bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && header_found_i |-> header_end_i >= OFFSET_BITS'(4))
    else $error("header end shorter than marker");

endmodule

bind http_header_length_parser_top hhlp_checker #(
  .OFFSET_BITS(OFFSET_BITS),
  .LENGTH_BITS(LENGTH_BITS)
) u_hhlp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .header_found_i   (out_o.header_found),
  .header_end_i     (out_o.header_end),
  .length_found_i   (out_o.length_found),
  .content_length_i (out_o.content_length)
);
